### rtl/tsa_pkg.sv
// Shared types, constants and helpers of the tiered slot allocator.
package tsa_pkg;

  localparam int NUM_CLASSES    = 4;
  localparam int CLASS_W        = $clog2(NUM_CLASSES);
  localparam int MAX_SLOTS      = 8;
  localparam int SLOT_W         = 3;
  localparam int FACES_PER_SLOT = 6;
  localparam int SLICE_W        = 6;
  localparam int CAP_W          = 4;
  localparam int RES_W          = 13;
  localparam int REQ_RES_W      = 16;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = RES_W;

  // Class thresholds on the requested resolution
  localparam logic [REQ_RES_W-1:0] CLASS0_LIMIT = REQ_RES_W'(128);
  localparam logic [REQ_RES_W-1:0] CLASS1_LIMIT = REQ_RES_W'(256);
  localparam logic [REQ_RES_W-1:0] CLASS2_LIMIT = REQ_RES_W'(512);

  // Register reset values
  localparam logic [CAP_W-1:0] CAP_RESET_SMALL = CAP_W'(8);
  localparam logic [CAP_W-1:0] CAP_RESET_TOP   = CAP_W'(4);
  localparam logic [RES_W-1:0] RES_RESET_C0    = RES_W'(128);
  localparam logic [RES_W-1:0] RES_RESET_C1    = RES_W'(256);
  localparam logic [RES_W-1:0] RES_RESET_C2    = RES_W'(512);
  localparam logic [RES_W-1:0] RES_RESET_C3    = RES_W'(1024);

  typedef enum logic {
    REQ_ALLOC       = 1'b0,
    REQ_FRAME_RESET = 1'b1
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAP0 = 4'd0,
    CFG_CAP1 = 4'd1,
    CFG_CAP2 = 4'd2,
    CFG_CAP3 = 4'd3,
    CFG_RES0 = 4'd4,
    CFG_RES1 = 4'd5,
    CFG_RES2 = 4'd6,
    CFG_RES3 = 4'd7
  } cfg_index_t;

  typedef logic [NUM_CLASSES-1:0][MAX_SLOTS-1:0] slot_maps_t;

  typedef struct packed {
    logic [NUM_CLASSES-1:0][CAP_W-1:0] capacity;
    logic [NUM_CLASSES-1:0][RES_W-1:0] resolution;
  } tsa_cfg_t;

  typedef struct packed {
    logic               granted;
    logic [CLASS_W-1:0] pool_class;
    logic [SLOT_W-1:0]  slot;
    logic [SLICE_W-1:0] first_slice;
    logic [RES_W-1:0]   resolution;
  } tsa_grant_t;

  // Map a requested resolution onto its size class
  function automatic logic [CLASS_W-1:0] pick_class(input logic [REQ_RES_W-1:0] res);
    logic [CLASS_W-1:0] cls;
    if (res <= CLASS0_LIMIT) cls = CLASS_W'(0);
    else if (res <= CLASS1_LIMIT) cls = CLASS_W'(1);
    else if (res <= CLASS2_LIMIT) cls = CLASS_W'(2);
    else cls = CLASS_W'(3);
    return cls;
  endfunction

  // Slots below the capacity, capacity saturated at the pool size
  function automatic logic [MAX_SLOTS-1:0] cap_mask(input logic [CAP_W-1:0] cap);
    logic [MAX_SLOTS-1:0] mask;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      mask[i] = (CAP_W'(i) < cap);
    end
    return mask;
  endfunction

endpackage

### rtl/tiered_slot_allocator_core.sv
// Tiered slot allocator: four size-class pools, first-free slot with fallback.
// A request is captured into input registers, allocated combinationally, and its result registered with done high.
// Throughput: one request per cycle; busy stays low.
// Each result shows for exactly one cycle; the receiver cannot stall it.
// Reset (rst, synchronous): all slots free, registers at their defaults, no result pending.
module tiered_slot_allocator_core import tsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type,
  input  logic [REQ_RES_W-1:0]  requested_resolution,
  output logic                  done,
  output logic                  granted,
  output logic [CLASS_W-1:0]    pool_class,
  output logic [SLOT_W-1:0]     slot_number,
  output logic [SLICE_W-1:0]    first_slice,
  output logic [RES_W-1:0]      granted_resolution,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tsa_cfg_t             cfg;
  slot_maps_t           marks;
  slot_maps_t           marks_next;
  tsa_grant_t           grant;
  logic                 in_valid;
  logic                 in_req_type;
  logic [REQ_RES_W-1:0] in_res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  tsa_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_req_type <= req_type;
    in_res      <= requested_resolution;
  end

  tsa_alloc u_alloc (
    .req_type             (in_req_type),
    .requested_resolution (in_res),
    .cfg                  (cfg),
    .marks                (marks),
    .marks_next           (marks_next),
    .grant                (grant)
  );

  // Advance the used-slot bitmaps
  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
    end else if (in_valid) begin
      marks <= marks_next;
    end
  end

  // Register the result and strobe it for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    granted            <= grant.granted;
    pool_class         <= grant.pool_class;
    slot_number        <= grant.slot;
    first_slice        <= grant.first_slice;
    granted_resolution <= grant.resolution;
  end

endmodule

### rtl/tsa_cfg_regs.sv
// Configuration register file: pool capacities and reported class resolutions.
module tsa_cfg_regs import tsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output tsa_cfg_t              cfg
);

  // Decode and hold register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity[0]   <= CAP_RESET_SMALL;
      cfg.capacity[1]   <= CAP_RESET_SMALL;
      cfg.capacity[2]   <= CAP_RESET_SMALL;
      cfg.capacity[3]   <= CAP_RESET_TOP;
      cfg.resolution[0] <= RES_RESET_C0;
      cfg.resolution[1] <= RES_RESET_C1;
      cfg.resolution[2] <= RES_RESET_C2;
      cfg.resolution[3] <= RES_RESET_C3;
    end else if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        CFG_CAP0: cfg.capacity[0]   <= wr_data[CAP_W-1:0];
        CFG_CAP1: cfg.capacity[1]   <= wr_data[CAP_W-1:0];
        CFG_CAP2: cfg.capacity[2]   <= wr_data[CAP_W-1:0];
        CFG_CAP3: cfg.capacity[3]   <= wr_data[CAP_W-1:0];
        CFG_RES0: cfg.resolution[0] <= wr_data[RES_W-1:0];
        CFG_RES1: cfg.resolution[1] <= wr_data[RES_W-1:0];
        CFG_RES2: cfg.resolution[2] <= wr_data[RES_W-1:0];
        CFG_RES3: cfg.resolution[3] <= wr_data[RES_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/tsa_alloc.sv
// Allocation logic: class pick, first-free search per pool, fallback, bitmap update.
module tsa_alloc import tsa_pkg::*; (
  input  logic                 req_type,
  input  logic [REQ_RES_W-1:0] requested_resolution,
  input  tsa_cfg_t             cfg,
  input  slot_maps_t           marks,
  output slot_maps_t           marks_next,
  output tsa_grant_t           grant
);

  logic [NUM_CLASSES-1:0][MAX_SLOTS-1:0] free_map;
  logic [NUM_CLASSES-1:0]                pool_has_free;
  logic [NUM_CLASSES-1:0][SLOT_W-1:0]    first_free;
  logic [CLASS_W-1:0]                    want_class;
  logic [CLASS_W-1:0]                    sel_class;
  logic                                  found;

  // Find the lowest free slot below capacity in every pool
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      free_map[c]      = ~marks[c] & cap_mask(cfg.capacity[c]);
      pool_has_free[c] = |free_map[c];
      first_free[c]    = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
        if (free_map[c][i]) first_free[c] = SLOT_W'(i);
      end
    end
  end

  // Take the highest class at or below the requested one that has room
  always_comb begin
    want_class = pick_class(requested_resolution);
    sel_class  = '0;
    found      = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if ((CLASS_W'(c) <= want_class) && pool_has_free[c]) begin
        sel_class = CLASS_W'(c);
        found     = 1'b1;
      end
    end
  end

  // Build the grant and the updated bitmaps
  always_comb begin
    grant      = '0;
    marks_next = marks;
    if (req_type_t'(req_type) == REQ_FRAME_RESET) begin
      marks_next = '0;
    end else if (found) begin
      grant.granted     = 1'b1;
      grant.pool_class  = sel_class;
      grant.slot        = first_free[sel_class];
      grant.first_slice = SLICE_W'(first_free[sel_class]) * SLICE_W'(FACES_PER_SLOT);
      grant.resolution  = cfg.resolution[sel_class];
      marks_next[sel_class][first_free[sel_class]] = 1'b1;
    end
  end

endmodule
